// File: design/dhfk_pkg.sv
// Shared constants and elaboration-time helpers for the DH forward-kinematics chain.
// No dependencies; used by the interfaces, the CORDIC unit and the top level.
package dhfk_pkg;

  // Field widths
  localparam int ANGLE_W = 17;
  localparam int LEN_W   = 24;
  localparam int ROT_W   = 16;
  localparam int POS_W   = 32;

  // Default parameter values
  localparam int ROT_FRACTION_BITS_DEF = 14;
  localparam int TRIG_ITERATIONS_DEF   = 16;

  // CORDIC working format: Q40 in a 43-bit signed word
  localparam int WORK_BITS = 40;
  localparam int ZW        = 43;
  localparam int PROD_W    = 55;  // |r| * pi in Q40
  localparam int RA_W      = 13;  // |residual angle|

  localparam longint PI_Q60  = 64'sh3243F6A8885A308D;
  localparam longint PI_Q40  = (PI_Q60 + (64'sd1 <<< 19)) >>> 20;
  localparam longint GAIN_X0 = 64'sh9B74EDA8 <<< (WORK_BITS - 32);

  // Angle units (1/128 degree)
  localparam int FULL_TURN        = 46080;
  localparam int QUARTER_TURN     = 11520;
  localparam int HALF_QUARTER     = 5760;
  localparam int DEG_UNITS_PER_PI = 23040;

  localparam longint ROT_MAX = 32767;
  localparam longint ROT_MIN = -32768;
  localparam longint POS_MAX = 64'sd2147483647;
  localparam longint POS_MIN = -64'sd2147483648;

  // Unsigned shift-subtract division, elaboration time only
  function automatic longint unsigned udiv64(longint unsigned num, longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = 0;
    rem = 0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      quo = quo << 1;
      if (rem >= den) begin
        rem = rem - den;
        quo = quo | 64'd1;
      end
    end
    return quo;
  endfunction

  // arctan(2^-i) in Q40: series summed in Q60, then rounded
  function automatic longint atan_q40(int i);
    longint sum;
    longint term;
    int     k;
    int     sh;
    sum = 0;
    k   = 0;
    if (i == 0) begin
      return ((PI_Q60 >>> 2) + (64'sd1 <<< 19)) >>> 20;
    end
    sh = i;
    while (sh <= 60) begin
      term = longint'(udiv64(64'd1 << (60 - sh), longint'(2 * k + 1)));
      if (k % 2 == 1) sum = sum - term;
      else sum = sum + term;
      k  = k + 1;
      sh = (2 * k + 1) * i;
    end
    return (sum + (64'sd1 <<< 19)) >>> 20;
  endfunction

  // Saturate a narrow signed value to 16 bits
  function automatic logic signed [ROT_W-1:0] sat16(longint v);
    if (v > ROT_MAX) return ROT_W'(ROT_MAX);
    if (v < ROT_MIN) return ROT_W'(ROT_MIN);
    return ROT_W'(v);
  endfunction

endpackage

// File: design/dhfk_if.sv
// Valid/ready channel interfaces: one link item in, one pose item out.
// Depends on dhfk_pkg for field widths.
interface dhfk_link_if;
  import dhfk_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [ANGLE_W-1:0]  joint_angle;
  logic signed [ANGLE_W-1:0]  link_twist;
  logic signed [LEN_W-1:0]    link_length;
  logic signed [LEN_W-1:0]    link_offset;
  logic                       chain_start;
  logic                       chain_end;

  modport source (output valid, joint_angle, link_twist, link_length, link_offset,
                  chain_start, chain_end, input ready);
  modport sink (input valid, joint_angle, link_twist, link_length, link_offset,
                chain_start, chain_end, output ready);
endinterface

interface dhfk_pose_if;
  import dhfk_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [ROT_W-1:0]  r00, r01, r02, r10, r11, r12, r20, r21, r22;
  logic signed [POS_W-1:0]  pos_x, pos_y, pos_z;

  modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                  pos_x, pos_y, pos_z, input ready);
  modport sink (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                pos_x, pos_y, pos_z, output ready);
endinterface

// File: design/dhfk_cordic.sv
// Iterative sine/cosine unit: angle reduction, shift-add scaling to radians with a
// short reciprocal step, then shared-adder CORDIC rotation steps. Depends on dhfk_pkg.
module dhfk_cordic #(
  parameter int ROT_FRACTION_BITS = dhfk_pkg::ROT_FRACTION_BITS_DEF,
  parameter int TRIG_ITERATIONS   = dhfk_pkg::TRIG_ITERATIONS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic signed [dhfk_pkg::ANGLE_W-1:0]   angle,
  output logic                                  done,
  output logic signed [ROT_FRACTION_BITS+1:0]   cos_out,
  output logic signed [ROT_FRACTION_BITS+1:0]   sin_out
);
  import dhfk_pkg::*;

  localparam int TW  = ROT_FRACTION_BITS + 2;
  localparam int IXW = $clog2(TRIG_ITERATIONS);
  localparam int SH  = WORK_BITS - ROT_FRACTION_BITS;

  // pi in Q40 per angle unit, split into quotient and remainder by 23040
  localparam longint PI_UNIT_Q = PI_Q40 / DEG_UNITS_PER_PI;
  localparam longint PI_UNIT_R = PI_Q40 % DEG_UNITS_PER_PI;
  localparam int     RW_W      = 15;             // remainder < 23040
  localparam int     FP_W      = RA_W + RW_W;    // |r| * remainder
  // 23040 = 45 * 2^9: floor by 2^9, then reciprocal multiply by 1/45
  localparam int     DIV_SH    = 9;
  localparam int     DIV_ODD   = DEG_UNITS_PER_PI >> DIV_SH;
  localparam int     RECIP_SH  = 25;
  localparam int     RECIP_W   = 20;
  localparam longint RECIP_ODD = ((64'sd1 <<< RECIP_SH) + DIV_ODD - 1) / DIV_ODD;
  localparam int     QW        = FP_W - DIV_SH + RECIP_W;

  typedef enum logic [2:0] {C_IDLE, C_MUL, C_DIV, C_ROT, C_FIN} cstate_t;
  cstate_t state;

  logic [1:0]              quad;
  logic                    rneg;
  logic [RA_W-1:0]         ra, ra_abs;
  logic [PROD_W-1:0]       mcand, prod;
  logic [FP_W-1:0]         frac_p;
  logic [QW-1:0]           frac_q;
  logic [5:0]              cnt;
  logic signed [ZW-1:0]    x, y, z;

  // arctangent constants, one per rotation step
  logic signed [ZW-1:0] atan_w [TRIG_ITERATIONS];
  for (genvar g = 0; g < TRIG_ITERATIONS; g++) begin : g_atan
    assign atan_w[g] = ZW'(atan_q40(g));
  end

  // reduce angle into quadrant and residual in [-45, 45) degrees
  logic signed [17:0] v0, v1, v2, v, r0, r;
  logic [1:0]         q0, q1;
  always_comb begin
    v0 = 18'(angle);
    v1 = (v0 < 0) ? v0 + 18'(FULL_TURN) : v0;
    v2 = (v1 < 0) ? v1 + 18'(FULL_TURN) : v1;
    v  = (v2 >= 18'(FULL_TURN)) ? v2 - 18'(FULL_TURN) : v2;
    if (v < 18'(QUARTER_TURN)) q0 = 2'd0;
    else if (v < 18'(2 * QUARTER_TURN)) q0 = 2'd1;
    else if (v < 18'(3 * QUARTER_TURN)) q0 = 2'd2;
    else q0 = 2'd3;
    r0 = v - 18'(QUARTER_TURN) * $signed({16'd0, q0});
    if (r0 >= 18'(HALF_QUARTER)) begin
      r  = r0 - 18'(QUARTER_TURN);
      q1 = q0 + 2'd1;
    end else begin
      r  = r0;
      q1 = q0;
    end
  end

  // scaled magnitude and rotation step datapath
  logic signed [ZW-1:0] zmag, dx, dy, t, cq, sq;
  always_comb begin
    zmag = $signed(ZW'(prod) + ZW'(frac_q[QW-1:RECIP_SH]));
    dx   = y >>> cnt;
    dy   = x >>> cnt;
    t    = atan_w[cnt[IXW-1:0]];
    case (quad)
      2'd0:    begin cq = x;  sq = y;  end
      2'd1:    begin cq = -y; sq = x;  end
      2'd2:    begin cq = -x; sq = -y; end
      default: begin cq = y;  sq = -x; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        C_IDLE: begin
          if (start) begin
            quad   <= q1;
            rneg   <= r < 0;
            ra     <= RA_W'((r < 0) ? -r : r);
            ra_abs <= RA_W'((r < 0) ? -r : r);
            mcand  <= PROD_W'(PI_UNIT_Q);
            prod   <= '0;
            cnt    <= '0;
            state  <= C_MUL;
          end
        end
        // shift-add multiply |r| * quotient part
        C_MUL: begin
          if (ra[0]) prod <= prod + mcand;
          mcand <= mcand << 1;
          ra    <= ra >> 1;
          cnt   <= cnt + 6'd1;
          if (cnt == 6'(RA_W - 1)) begin
            cnt   <= '0;
            state <= C_DIV;
          end
        end
        // remainder part: |r| * rem / 23040 by reciprocal, three steps
        C_DIV: begin
          cnt <= cnt + 6'd1;
          case (cnt)
            6'd0:    frac_p <= FP_W'(ra_abs) * FP_W'(PI_UNIT_R);
            6'd1:    frac_q <= QW'(frac_p[FP_W-1:DIV_SH]) * QW'(RECIP_ODD);
            default: begin
              z     <= rneg ? -zmag : zmag;
              x     <= ZW'(GAIN_X0);
              y     <= '0;
              cnt   <= '0;
              state <= C_ROT;
            end
          endcase
        end
        C_ROT: begin
          if (z >= 0) begin
            x <= x - dx;
            y <= y + dy;
            z <= z - t;
          end else begin
            x <= x + dx;
            y <= y - dy;
            z <= z + t;
          end
          cnt <= cnt + 6'd1;
          if (cnt == 6'(TRIG_ITERATIONS - 1)) state <= C_FIN;
        end
        // quadrant fix-up and round half up
        C_FIN: begin
          cos_out <= TW'((cq + (ZW'(1) <<< (SH - 1))) >>> SH);
          sin_out <= TW'((sq + (ZW'(1) <<< (SH - 1))) >>> SH);
          done    <= 1'b1;
          state   <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

endmodule

// File: design/dh_forward_kinematics_chain_unit.sv
// Top level of the modified-DH forward-kinematics chain: sequencer, one shared
// multiplier, accumulated transform. Depends on dhfk_pkg, dhfk_if, dhfk_cordic.

// One link item occupies the block until its transform is committed, plus an emit
// step when chain_end asks for a pose; when chain_start restarts the product, the
// matrix update is skipped.
// The two sine/cosine evaluations run back to back through one iterative CORDIC
// unit (13 shift-add steps, 3 scaling steps and TRIG_ITERATIONS rotations each,
// plus start, idle and finish cycles), and then all link terms and the 36
// products of the 3x4 update pass through a single registered multiplier, each
// product in a multiply phase and then a result phase. link.ready is high only
// between items; a finished pose waits in its output register while the next link
// is taken, and the emit step stalls only while an earlier pose is still held there.
module dh_forward_kinematics_chain_unit #(
  parameter int ROT_FRACTION_BITS = dhfk_pkg::ROT_FRACTION_BITS_DEF,
  parameter int TRIG_ITERATIONS   = dhfk_pkg::TRIG_ITERATIONS_DEF
) (
  input logic        clk,
  input logic        rst,
  dhfk_link_if.sink  link,
  dhfk_pose_if.source pose
);
  import dhfk_pkg::*;

  localparam int F     = ROT_FRACTION_BITS;
  localparam int TW    = F + 2;
  localparam int LW    = TW + 1;
  localparam int PW    = LEN_W + 1;
  localparam int MW    = (LW > PW) ? LW : PW;
  localparam int PRW   = 2 * MW;
  localparam int SW    = PRW + 2;
  localparam int ROT_ONE_I = (F >= 15) ? 32767 : (1 << F);
  localparam logic signed [ROT_W-1:0] ROT_ONE = ROT_W'(ROT_ONE_I);

  typedef enum logic [2:0] {
    S_IDLE, S_TRIG_T, S_TRIG_A, S_LINK, S_MAT, S_COMMIT, S_EMIT
  } state_t;
  state_t state;

  logic signed [ANGLE_W-1:0] theta, alpha;
  logic signed [LEN_W-1:0]   d_off;
  logic                      f_start, f_end;
  logic signed [TW-1:0]      ct, st, ca, sa;
  logic signed [LW-1:0]      lr [9];
  logic signed [PW-1:0]      lp [3];
  logic signed [ROT_W-1:0]   rot [9];
  logic signed [POS_W-1:0]   tacc [3];
  logic signed [ROT_W-1:0]   nrot [9];
  logic signed [POS_W-1:0]   npos [3];
  logic signed [PRW-1:0]     prod_r;
  logic signed [SW-1:0]      sum_r;
  logic [2:0]                cnt;
  logic [1:0]                row, col, kk;
  logic                      ph;
  logic                      cstart;

  // trig unit
  logic                      cdone;
  logic signed [TW-1:0]      ccos, csin;
  dhfk_cordic #(
    .ROT_FRACTION_BITS(ROT_FRACTION_BITS),
    .TRIG_ITERATIONS  (TRIG_ITERATIONS)
  ) u_cordic (
    .clk    (clk),
    .rst    (rst),
    .start  (cstart),
    .angle  ((state == S_TRIG_A) ? alpha : theta),
    .done   (cdone),
    .cos_out(ccos),
    .sin_out(csin)
  );

  // shared multiplier operand select
  logic signed [MW-1:0]  mul_a, mul_b;
  logic [3:0]            rk_idx, lr_idx;
  always_comb begin
    rk_idx = 4'({2'b0, row} * 4'd3 + {2'b0, kk});
    lr_idx = 4'({2'b0, kk} * 4'd3 + {2'b0, col});
    mul_a  = '0;
    mul_b  = '0;
    if (state == S_LINK) begin
      case (cnt)
        3'd0:    begin mul_a = MW'(st);   mul_b = MW'(ca);    end
        3'd1:    begin mul_a = MW'(ct);   mul_b = MW'(ca);    end
        3'd2:    begin mul_a = MW'(st);   mul_b = MW'(sa);    end
        3'd3:    begin mul_a = MW'(ct);   mul_b = MW'(sa);    end
        3'd4:    begin mul_a = -MW'(sa);  mul_b = MW'(d_off); end
        3'd5:    begin mul_a = MW'(ca);   mul_b = MW'(d_off); end
        default: begin mul_a = '0;        mul_b = '0;         end
      endcase
    end else if (state == S_MAT) begin
      mul_a = MW'(rot[rk_idx]);
      mul_b = (col == 2'd3) ? MW'(lp[kk]) : MW'(lr[lr_idx]);
    end
  end

  // rounding of single products and of three-term sums
  logic signed [PRW-1:0]  prod_rnd;
  logic signed [SW-1:0]   s_cur, s_rnd;
  logic signed [SW:0]     t_sum;
  logic signed [ROT_W-1:0] rot_sat;
  logic signed [POS_W-1:0] pos_sat;
  always_comb begin
    prod_rnd = (prod_r + (PRW'(1) <<< (F - 1))) >>> F;
    s_cur    = (kk == 2'd0) ? SW'(prod_r) : sum_r + SW'(prod_r);
    s_rnd    = (s_cur + (SW'(1) <<< (F - 1))) >>> F;
    t_sum    = (SW + 1)'(s_rnd) + (SW + 1)'(tacc[row]);
    if (s_rnd > SW'(ROT_MAX)) rot_sat = ROT_W'(ROT_MAX);
    else if (s_rnd < SW'(ROT_MIN)) rot_sat = ROT_W'(ROT_MIN);
    else rot_sat = ROT_W'(s_rnd);
    if (t_sum > (SW + 1)'(POS_MAX)) pos_sat = POS_W'(POS_MAX);
    else if (t_sum < (SW + 1)'(POS_MIN)) pos_sat = POS_W'(POS_MIN);
    else pos_sat = POS_W'(t_sum);
  end

  assign link.ready = (state == S_IDLE);

  // sequencer, accumulators and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cstart     <= 1'b0;
      pose.valid <= 1'b0;
      for (int k = 0; k < 9; k++) rot[k] <= (k % 4 == 0) ? ROT_ONE : '0;
      for (int k = 0; k < 3; k++) tacc[k] <= '0;
    end else begin
      cstart <= 1'b0;
      // the emit step reloads the register itself
      if (pose.valid && pose.ready && state != S_EMIT) pose.valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (link.valid) begin
            theta   <= link.joint_angle;
            alpha   <= link.link_twist;
            lp[0]   <= PW'(link.link_length);
            d_off   <= link.link_offset;
            f_start <= link.chain_start;
            f_end   <= link.chain_end;
            cstart  <= 1'b1;
            state   <= S_TRIG_T;
          end
        end
        S_TRIG_T: begin
          if (cdone) begin
            ct     <= ccos;
            st     <= csin;
            cstart <= 1'b1;
            state  <= S_TRIG_A;
          end
        end
        S_TRIG_A: begin
          if (cdone) begin
            ca    <= ccos;
            sa    <= csin;
            lr[0] <= LW'(ct);
            lr[1] <= -LW'(st);
            lr[2] <= '0;
            lr[5] <= -LW'(csin);
            lr[8] <= LW'(ccos);
            cnt   <= '0;
            ph    <= 1'b0;
            state <= S_LINK;
          end
        end
        // six rounded link products
        S_LINK: begin
          ph <= ~ph;
          if (!ph) begin
            prod_r <= mul_a * mul_b;
          end else begin
            case (cnt)
              3'd0:    lr[3] <= LW'(prod_rnd);
              3'd1:    lr[4] <= LW'(prod_rnd);
              3'd2:    lr[6] <= LW'(prod_rnd);
              3'd3:    lr[7] <= LW'(prod_rnd);
              3'd4:    lp[1] <= PW'(prod_rnd);
              default: lp[2] <= PW'(prod_rnd);
            endcase
            cnt <= cnt + 3'd1;
            if (cnt == 3'd5) begin
              row   <= '0;
              col   <= '0;
              kk    <= '0;
              state <= f_start ? S_COMMIT : S_MAT;
            end
          end
        end
        // accumulated 3x4 times link transform, one product at a time through the shared multiplier
        S_MAT: begin
          ph <= ~ph;
          if (!ph) begin
            prod_r <= mul_a * mul_b;
          end else begin
            sum_r <= s_cur;
            kk    <= kk + 2'd1;
            if (kk == 2'd2) begin
              kk <= '0;
              if (col == 2'd3) npos[row] <= pos_sat;
              else nrot[rk_idx - 4'd2 + 4'(col)] <= rot_sat;
              col <= col + 2'd1;
              if (col == 2'd3) begin
                row <= row + 2'd1;
                if (row == 2'd2) state <= S_COMMIT;
              end
            end
          end
        end
        S_COMMIT: begin
          for (int k = 0; k < 9; k++)
            rot[k] <= f_start ? sat16(longint'(lr[k])) : nrot[k];
          for (int k = 0; k < 3; k++)
            tacc[k] <= f_start ? POS_W'(lp[k]) : npos[k];
          state <= f_end ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          if (!pose.valid || pose.ready) begin
            pose.valid <= 1'b1;
            pose.r00   <= rot[0];
            pose.r01   <= rot[1];
            pose.r02   <= rot[2];
            pose.r10   <= rot[3];
            pose.r11   <= rot[4];
            pose.r12   <= rot[5];
            pose.r20   <= rot[6];
            pose.r21   <= rot[7];
            pose.r22   <= rot[8];
            pose.pos_x <= tacc[0];
            pose.pos_y <= tacc[1];
            pose.pos_z <= tacc[2];
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // one item at a time: taking an item closes the input
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (link.valid && link.ready) |=> !link.ready)
    else $error("link accepted while busy");

  // trig results only arrive while the sequencer waits for them
  a_cordic_done_expected: assert property (@(posedge clk) disable iff (rst)
    cdone |-> (state == S_TRIG_T || state == S_TRIG_A))
    else $error("unexpected trig completion");

  // reset leaves an identity rotation and zero translation
  a_reset_identity: assert property (@(posedge clk)
    rst |=> (rot[0] == ROT_ONE && rot[4] == ROT_ONE && rot[1] == '0 && tacc[2] == '0))
    else $error("accumulator not at identity after reset");

  // a pose is only loaded from the emit step
  a_emit_source: assert property (@(posedge clk) disable iff (rst)
    $rose(pose.valid) |-> $past(state == S_EMIT))
    else $error("pose raised outside emit step");

endmodule

// File: dv/dhfk_checker.sv
// Pose checker for the DH forward-kinematics chain: predicts each pose from accepted link items.
// Depends on dhfk_pkg and the dhfk_if interfaces.
module dhfk_checker #(
  parameter int ROT_FRACTION_BITS = dhfk_pkg::ROT_FRACTION_BITS_DEF,
  parameter int TRIG_ITERATIONS   = dhfk_pkg::TRIG_ITERATIONS_DEF
) (
  input logic clk,
  input logic rst,
  dhfk_link_if link,
  dhfk_pose_if pose,
  output int  fail_count,
  output int  poses_pending,
  output int  poses_seen
);
  import dhfk_pkg::*;

  typedef struct {
    longint rot[9];
    longint pos[3];
  } pose_t;

  longint chain_rot[9];
  longint chain_pos[3];
  pose_t  expected_poses[$];
  longint atan_tab[64];

  function automatic longint floor_sh(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_sh(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // arctan(2^-i) in Q40, series summed in Q60
  function automatic longint arctan_step(int i);
    longint sum;
    longint term;
    int     k;
    int     sh;
    sum = 0;
    if (i == 0) return ((PI_Q60 >>> 2) + (64'sd1 <<< 19)) >>> 20;
    for (k = 0; ; k++) begin
      sh = (2 * k + 1) * i;
      if (sh > 60) break;
      term = longint'((64'd1 << (60 - sh)) / longint'(2 * k + 1));
      if (k % 2 == 1) sum = sum - term;
      else sum = sum + term;
    end
    return (sum + (64'sd1 <<< 19)) >>> 20;
  endfunction

  // Sine and cosine of an angle in 1/128 degree, rounded to the rotation format
  task automatic trig(input logic signed [ANGLE_W-1:0] ang, output longint c,
                      output longint s);
    longint v, q, r, z, x, y, dx, dy, cq, sq;
    v = longint'(ang) % FULL_TURN;
    if (v < 0) v += FULL_TURN;
    q = v / QUARTER_TURN;
    r = v - q * QUARTER_TURN;
    if (r >= HALF_QUARTER) begin
      r -= QUARTER_TURN;
      q++;
    end
    q = q & 3;
    z = r * PI_Q40 / DEG_UNITS_PER_PI;
    x = GAIN_X0;
    y = 0;
    for (int i = 0; i < TRIG_ITERATIONS; i++) begin
      dx = floor_sh(y, i);
      dy = floor_sh(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab[i];
      end else begin
        x += dx; y -= dy; z += atan_tab[i];
      end
    end
    case (q)
      0: begin cq = x;  sq = y;  end
      1: begin cq = -y; sq = x;  end
      2: begin cq = -x; sq = -y; end
      default: begin cq = y; sq = -x; end
    endcase
    c = round_sh(cq, WORK_BITS - ROT_FRACTION_BITS);
    s = round_sh(sq, WORK_BITS - ROT_FRACTION_BITS);
  endtask

  function automatic longint fmul(longint a, longint b);
    return round_sh(a * b, ROT_FRACTION_BITS);
  endfunction

  function automatic longint unity();
    longint one;
    one = 64'sd1 <<< ROT_FRACTION_BITS;
    return one > ROT_MAX ? ROT_MAX : one;
  endfunction

  // Apply one link to the running transform; queue a pose on chain end
  task automatic advance_chain();
    longint ct, st, ca, sa, a, d, sum, acc;
    longint lr[9];
    longint lp[3];
    longint nr[9];
    longint np[3];
    pose_t  p;
    trig(link.joint_angle, ct, st);
    trig(link.link_twist, ca, sa);
    a = longint'(link.link_length);
    d = longint'(link.link_offset);
    lr = '{ct, -st, 0, fmul(st, ca), fmul(ct, ca), -sa, fmul(st, sa), fmul(ct, sa), ca};
    lp = '{a, round_sh(-sa * d, ROT_FRACTION_BITS), round_sh(ca * d, ROT_FRACTION_BITS)};
    if (link.chain_start) begin
      foreach (nr[k]) nr[k] = clip(lr[k], ROT_MIN, ROT_MAX);
      foreach (np[k]) np[k] = clip(lp[k], POS_MIN, POS_MAX);
    end else begin
      for (int row = 0; row < 3; row++) begin
        acc = 0;
        for (int col = 0; col < 3; col++) begin
          sum = 0;
          for (int k = 0; k < 3; k++) sum += chain_rot[row*3+k] * lr[k*3+col];
          nr[row*3+col] = clip(round_sh(sum, ROT_FRACTION_BITS), ROT_MIN, ROT_MAX);
          acc += chain_rot[row*3+col] * lp[col];
        end
        np[row] = clip(round_sh(acc, ROT_FRACTION_BITS) + chain_pos[row], POS_MIN, POS_MAX);
      end
    end
    chain_rot = nr;
    chain_pos = np;
    if (link.chain_end) begin
      p.rot = nr;
      p.pos = np;
      expected_poses.push_back(p);
    end
  endtask

  task automatic report(input string what, input longint got, input longint want);
    $display("[%0t] pose mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  // Compare one accepted pose with the oldest expected one
  task automatic check_pose();
    pose_t  p;
    longint got[12];
    string  nm[12];
    nm = '{"r00", "r01", "r02", "r10", "r11", "r12", "r20", "r21", "r22",
           "pos_x", "pos_y", "pos_z"};
    got = '{longint'(pose.r00), longint'(pose.r01), longint'(pose.r02),
            longint'(pose.r10), longint'(pose.r11), longint'(pose.r12),
            longint'(pose.r20), longint'(pose.r21), longint'(pose.r22),
            longint'(pose.pos_x), longint'(pose.pos_y), longint'(pose.pos_z)};
    poses_seen++;
    if (expected_poses.size() == 0) begin
      $display("[%0t] pose item with nothing expected", $realtime);
      fail_count++;
      return;
    end
    p = expected_poses.pop_front();
    for (int k = 0; k < 9; k++)
      if (got[k] != p.rot[k]) report(nm[k], got[k], p.rot[k]);
    for (int k = 0; k < 3; k++)
      if (got[9+k] != p.pos[k]) report(nm[9+k], got[9+k], p.pos[k]);
  endtask

  initial begin
    fail_count = 0;
    poses_seen = 0;
    for (int i = 0; i < 64; i++) atan_tab[i] = arctan_step(i);
    foreach (chain_rot[k]) chain_rot[k] = (k % 4 == 0) ? unity() : 0;
    foreach (chain_pos[k]) chain_pos[k] = 0;
  end

  assign poses_pending = expected_poses.size();

  // Sample both channels at the edge; stimulus changes after it
  always @(posedge clk) begin
    if (!rst) begin
      if (pose.valid && pose.ready) check_pose();
      if (link.valid && link.ready) advance_chain();
    end
  end
endmodule

// File: dv/testbench.sv
// Top of the DH forward-kinematics chain testbench: clock, reset, link stimulus, verdict.
// Depends on dhfk_pkg, dhfk_if, the block and dhfk_checker.
module testbench;
  import dhfk_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   poses_pending;
  int   poses_seen;
  int   links_sent;
  int   stall_mode;

  dhfk_link_if link ();
  dhfk_pose_if pose ();

  dh_forward_kinematics_chain_unit dut (.clk(clk), .rst(rst), .link(link), .pose(pose));
  dhfk_checker chk (.clk(clk), .rst(rst), .link(link), .pose(pose), .fail_count(fail_count),
                    .poses_pending(poses_pending), .poses_seen(poses_seen));

  always #6 clk = ~clk;

  // Hard stop: time for every link plus gaps and stalls, with wide margin
  initial begin
    #(64'd12 * 64'd6000000);
    $display("timeout");
    $display("FAILURE");
    $finish;
  end

  // Receiver stalls in phases: none, light, heavy
  always @(posedge clk) begin
    if (rst) begin
      pose.ready <= 1'b0;
      stall_mode <= 0;
    end else begin
      if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
        0: pose.ready <= 1'b1;
        1: pose.ready <= ($urandom_range(0, 3) != 0);
        default: pose.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Present one link item and hold it until accepted
  task automatic send_link(input logic signed [ANGLE_W-1:0] th,
                           input logic signed [ANGLE_W-1:0] al,
                           input logic signed [LEN_W-1:0] a, input logic signed [LEN_W-1:0] d,
                           input logic st, input logic en);
    link.valid       <= 1'b1;
    link.joint_angle <= th;
    link.link_twist  <= al;
    link.link_length <= a;
    link.link_offset <= d;
    link.chain_start <= st;
    link.chain_end   <= en;
    do @(posedge clk); while (!link.ready);
    links_sent++;
  endtask

  task automatic idle_gap();
    int n;
    n = $urandom_range(0, 3) == 0 ? $urandom_range(1, 300) : 0;
    if (n > 0) begin
      link.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic logic signed [ANGLE_W-1:0] rand_angle();
    case ($urandom_range(0, 3))
      0: return ANGLE_W'($urandom);
      1: return ANGLE_W'($urandom_range(0, 8) * HALF_QUARTER - 4 * QUARTER_TURN);
      default: return ANGLE_W'(int'($urandom_range(0, 2 * FULL_TURN)) - FULL_TURN);
    endcase
  endfunction

  function automatic logic signed [LEN_W-1:0] rand_len();
    case ($urandom_range(0, 3))
      0: return LEN_W'($urandom);
      1: return ($urandom_range(0, 1) ? 24'sh7FFFFF : -24'sh800000);
      default: return LEN_W'(int'($urandom_range(0, 200000)) - 100000);
    endcase
  endfunction

  logic signed [ANGLE_W-1:0] edge_angles[10];
  int chain_len;

  initial begin
    edge_angles = '{17'sh0FFFF, -17'sh10000, 17'sd46080, -17'sd46080, 17'sd0,
                    17'sd5760, 17'sd5759, -17'sd5760, 17'sd11520, 17'sd23040};
    links_sent = 0;
    link.valid       = 1'b0;
    link.joint_angle = '0;
    link.link_twist  = '0;
    link.link_length = '0;
    link.link_offset = '0;
    link.chain_start = 1'b0;
    link.chain_end   = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: link before any start flag, angle extremes, length extremes, saturation
    send_link(17'sd3000, -17'sd2000, 24'sd1000, 24'sd500, 1'b0, 1'b1);
    foreach (edge_angles[i])
      send_link(edge_angles[i], edge_angles[9 - i], (i % 2) ? 24'sh7FFFFF : -24'sh800000,
                (i % 2) ? -24'sh800000 : 24'sh7FFFFF, i == 0, i % 3 == 2);
    send_link(17'sd0, 17'sd0, 24'sd5, -24'sd5, 1'b1, 1'b1);
    for (int i = 0; i < 8; i++)
      send_link(17'sd0, 17'sd0, 24'sh7FFFFF, 24'sh7FFFFF, 1'b0, i == 7);

    // Random chains with random content, plus some loose noise links
    while (links_sent < 1800) begin
      if ($urandom_range(0, 5) == 0) begin
        send_link(rand_angle(), rand_angle(), rand_len(), rand_len(),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else begin
        chain_len = $urandom_range(1, 7);
        for (int i = 0; i < chain_len; i++)
          send_link(rand_angle(), rand_angle(), rand_len(), rand_len(),
                    i == 0, i == chain_len - 1);
      end
      idle_gap();
    end
    link.valid <= 1'b0;

    while (poses_pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    $display("Sent %0d link items in chains of 1..7 links with gaps and output stalls;",
             links_sent);
    $display("checked %0d poses, %0d mismatches", poses_seen, fail_count);
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule
